FILE: sv/ternary_dot_requantizer_top_defines.svh
// ----------------------------------------------------------------------------
// Ternary dot requantizer assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef TERNARY_DOT_REQUANTIZER_TOP_DEFINES_SVH
`define TERNARY_DOT_REQUANTIZER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TDR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TDR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/tdr_pkg.sv
// ----------------------------------------------------------------------------
// Ternary dot requantizer package
// Payload structs, weight codes, register indexes and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package tdr_pkg;

	localparam int LANES      = 4;
	localparam int ACC_WIDTH  = 32;
	localparam int MULT_WIDTH = 31;
	localparam int PROD_WIDTH = ACC_WIDTH + MULT_WIDTH;
	localparam int RND_WIDTH  = PROD_WIDTH + 1;
	localparam int LANE_SUM_W = 11;

	// Ternary weight codes.
	localparam logic [1:0] CODE_ZERO = 2'b00;
	localparam logic [1:0] CODE_POS  = 2'b01;
	localparam logic [1:0] CODE_NEG  = 2'b10;
	localparam logic [1:0] CODE_RSVD = 2'b11;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SHIFT = 2'd0;
	localparam logic [1:0] CFG_TAIL  = 2'd1;
	localparam logic [1:0] CFG_RELU  = 2'd2;

	localparam logic signed [7:0] SAT_MAX = 8'sd127;
	localparam logic signed [7:0] SAT_MIN = -8'sd128;

	typedef struct packed {
		logic signed [7:0]       act0;
		logic signed [7:0]       act1;
		logic signed [7:0]       act2;
		logic signed [7:0]       act3;
		logic [7:0]              weight_byte;
		logic [MULT_WIDTH-1:0]   multiplier;
		logic                    last;
	} item_t;

	typedef struct packed {
		logic signed [7:0] result;
		logic              weight_error;
	} result_t;

endpackage

`default_nettype wire

FILE: sv/ternary_dot_requantizer_top.sv
// ----------------------------------------------------------------------------
// Ternary dot requantizer
// Ternary-weight int8 dot product with per-row requantization to int8.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle unless stalled, each carrying
// four signed int8 activations and a byte of four 2-bit ternary weight
// codes (01 is +1, 10 is -1, 00 is 0, 11 is reserved, counts as 0 and flags
// an error), and accumulates the products into a 32-bit row sum that wraps
// on overflow. The request with last set closes the row: its sum is
// multiplied by that request's 31-bit multiplier, rounded by half an LSB
// when shift is nonzero, shifted arithmetically right, saturated to int8
// and optionally clamped at zero. Exactly one result leaves per row, through
// the stage 2, stage 3 and output registers. Throughput is one request per
// cycle unless stalled, set by the single accumulator add that feeds back
// into the row sum each cycle; the multiply and the round/shift/saturate
// step each take a pipeline stage of their own. Every stage moves
// independently, so a stalled result does not block new requests until all
// stages are full. Configuration writes are always accepted and should only
// be issued while no row is in flight.
`default_nettype none

module ternary_dot_requantizer_top (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_ready,
	input  wire tdr_pkg::item_t  item,
	output logic                 res_valid,
	input  wire logic            res_ready,
	output tdr_pkg::result_t     res,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [5:0]      cfg_data
);

	import tdr_pkg::*;

	`include "ternary_dot_requantizer_top_defines.svh"

	// Configuration registers.
	logic [5:0] shift_q;
	logic [1:0] tail_q;
	logic       relu_q;

	// Stage 1: registered input request.
	logic  valid_s1;
	item_t item_s1;

	// Row accumulator.
	logic signed [ACC_WIDTH-1:0] row_sum_q;
	logic                        row_fault_q;

	// Stage 2: finished row sum and its multiplier.
	logic                         valid_s2;
	logic signed [ACC_WIDTH-1:0]  sum_s2;
	logic [MULT_WIDTH-1:0]        mult_s2;
	logic                         fault_s2;

	// Stage 3: exact product.
	logic                         valid_s3;
	logic signed [PROD_WIDTH-1:0] prod_s3;
	logic                         fault_s3;

	// Output register.
	logic    res_valid_q;
	result_t res_q;

	// Flow control.
	logic out_free, s3_free, s2_free, s1_free, s1_go;

	// Stage 1 datapath.
	logic signed [7:0]            act_s1 [LANES];
	logic signed [LANE_SUM_W-1:0] lane_sum;
	logic                         lane_fault;
	logic signed [ACC_WIDTH-1:0]  new_sum;
	logic                         new_fault;

	// Stage 2 and 3 datapath.
	logic signed [MULT_WIDTH:0]   mult_ext;
	logic signed [PROD_WIDTH-1:0] product;
	logic signed [RND_WIDTH-1:0]  rnd_add;
	logic signed [RND_WIDTH-1:0]  rounded;
	logic signed [RND_WIDTH-1:0]  shifted;
	logic signed [7:0]            sat_val;
	result_t                      res_next;

	// A stage can load when it is empty or its content moves on this cycle.
	assign out_free   = !res_valid_q || res_ready;
	assign s3_free    = !valid_s3 || out_free;
	assign s2_free    = !valid_s2 || s3_free;
	assign s1_free    = !valid_s1 || s2_free;
	assign s1_go      = valid_s1 && s2_free;
	assign item_ready = s1_free;
	assign cfg_ready  = 1'b1;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			tail_q  <= '0;
			relu_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SHIFT: shift_q <= cfg_data;
				CFG_TAIL:  tail_q  <= cfg_data[1:0];
				CFG_RELU:  relu_q  <= cfg_data[0];
				default:   ;
			endcase
		end
	end

	// Lane products. On the row's closing request with a nonzero tail count,
	// lanes at and above the count are padding: they add nothing and any
	// nonzero code there is an error.
	assign act_s1[0] = item_s1.act0;
	assign act_s1[1] = item_s1.act1;
	assign act_s1[2] = item_s1.act2;
	assign act_s1[3] = item_s1.act3;

	always_comb begin
		logic [2:0] n_lanes;
		logic [1:0] code;
		n_lanes    = (item_s1.last && (tail_q != 2'd0)) ? {1'b0, tail_q} : 3'(LANES);
		lane_sum   = '0;
		lane_fault = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			code = item_s1.weight_byte[2*i +: 2];
			if (3'(i) >= n_lanes) begin
				if (code != CODE_ZERO) begin
					lane_fault = 1'b1;
				end
			end else begin
				case (code)
					CODE_POS:  lane_sum = lane_sum + LANE_SUM_W'(act_s1[i]);
					CODE_NEG:  lane_sum = lane_sum - LANE_SUM_W'(act_s1[i]);
					CODE_RSVD: lane_fault = 1'b1;
					default:   ;
				endcase
			end
		end
		new_sum   = row_sum_q + ACC_WIDTH'(lane_sum);
		new_fault = row_fault_q || lane_fault;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			row_sum_q   <= '0;
			row_fault_q <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= item_valid;
			end
			if (s1_go) begin
				if (item_s1.last) begin
					row_sum_q   <= '0;
					row_fault_q <= 1'b0;
				end else begin
					row_sum_q   <= new_sum;
					row_fault_q <= new_fault;
				end
			end
			if (s2_free) begin
				valid_s2 <= s1_go && item_s1.last;
			end
			if (s3_free) begin
				valid_s3 <= valid_s2;
			end
			if (out_free) begin
				res_valid_q <= valid_s3;
			end
		end
	end

	// Multiply, then round, shift and saturate.
	assign mult_ext = {1'b0, mult_s2};
	assign product  = PROD_WIDTH'(sum_s2 * mult_ext);

	always_comb begin
		logic [RND_WIDTH-8:0] upper;
		if (shift_q == 6'd0) begin
			rnd_add = '0;
		end else begin
			rnd_add = RND_WIDTH'(1) << (shift_q - 6'd1);
		end
		rounded = RND_WIDTH'(prod_s3) + rnd_add;
		shifted = rounded >>> shift_q;
		upper   = shifted[RND_WIDTH-1:7];
		if (shifted[RND_WIDTH-1] && !(&upper)) begin
			sat_val = SAT_MIN;
		end else if (!shifted[RND_WIDTH-1] && (|upper)) begin
			sat_val = SAT_MAX;
		end else begin
			sat_val = shifted[7:0];
		end
		res_next.result       = (relu_q && sat_val[7]) ? '0 : sat_val;
		res_next.weight_error = fault_s3;
	end

	always_ff @(posedge clk) begin
		if (s1_free && item_valid) begin
			item_s1 <= item;
		end
		if (s2_free) begin
			sum_s2   <= new_sum;
			mult_s2  <= item_s1.multiplier;
			fault_s2 <= new_fault;
		end
		if (s3_free) begin
			prod_s3  <= product;
			fault_s3 <= fault_s2;
		end
		if (out_free) begin
			res_q <= res_next;
		end
	end

	`TDR_ASSERT_NEXT(a_row_clears, s1_go && item_s1.last,
		(row_sum_q == '0) && !row_fault_q, "row state not cleared after closing request")
	`TDR_ASSERT_NEXT(a_row_accum, s1_go && !item_s1.last,
		row_sum_q == $past(new_sum), "row sum did not take the accumulated value")
	`TDR_ASSERT_NEXT(a_relu_clamp, out_free && valid_s3 && relu_q,
		!res_q.result[7], "negative result with ReLU enabled")
	`TDR_ASSERT_SAME(a_stall_full, !item_ready,
		valid_s1 && valid_s2 && valid_s3 && res_valid_q, "input stalled with a free stage")

endmodule

`default_nettype wire
